/* rtl/pss_pkg.sv */
// Shared types and constants for the PDM sample streamer.
package pss_pkg;

    localparam int RING_DEPTH  = 1024;
    localparam int PRIME_LEVEL = 512;
    localparam int IDX_W       = $clog2(RING_DEPTH);

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 8;
    localparam int HOLD_W     = 8;
    localparam int SETTLE_W   = 16;
    localparam int ACC_W      = 18;
    localparam int PLAYED_W   = 32;
    localparam int FILL_W     = 10;
    localparam int DUR_W      = 5;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SLOTS_PER_CYCLE = 6;
    localparam int LONG_US         = 21;
    localparam int SHORT_US        = 20;
    localparam int ACCUM_POS_STEP  = 32767;
    localparam int ACCUM_NEG_STEP  = 32768;
    localparam int SAMPLE_MAX      = 32767;
    localparam int SAMPLE_MIN      = -32768;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ACT_PUSH,
        ACT_TICK,
        ACT_START,
        ACT_RESUME,
        ACT_STOP,
        ACT_END,
        ACT_DRAIN,
        ACT_CLEAR
    } pss_action_t;

    typedef enum logic [1:0] {
        SEL_KEEP,
        SEL_ZERO,
        SEL_NEW,
        SEL_CLEAR
    } pss_sel_t;

    typedef struct packed {
        logic [2:0]                 action;
        logic signed [SAMPLE_W-1:0] sample;
    } pss_in_t;

    typedef struct packed {
        logic                accepted;
        logic                level;
        logic [DUR_W-1:0]    duration_us;
        logic                finished;
        logic [FILL_W-1:0]   fill;
        logic [PLAYED_W-1:0] played;
    } pss_out_t;

    typedef struct packed {
        logic                       accepted;
        logic                       finished;
        logic                       made_bit;
        logic [DUR_W-1:0]           dur;
        logic [FILL_W-1:0]          fill;
        logic [PLAYED_W-1:0]        played;
        pss_sel_t                   sel;
        logic signed [SAMPLE_W-1:0] sample;
    } pss_entry_t;

endpackage

/* rtl/pss_front.sv */
// Front end: ring storage, item classification and all data-independent control state.
module pss_front import pss_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pss_in_t               in_item,
    input  logic                  cfg_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [GAIN_W-1:0]     gain,
    output logic                  entry_valid,
    input  logic                  entry_ready,
    output pss_entry_t            entry
);

    localparam logic [IDX_W-1:0] PRIME_NEED = IDX_W'(PRIME_LEVEL);
    localparam logic [IDX_W-1:0] DRAIN_NEED = IDX_W'(1);

    logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                primed_reg, primed_next;
    logic                drain_reg, drain_next;
    logic                running_reg, running_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;
    logic [HOLD_W-1:0]   phase_reg, phase_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [PLAYED_W-1:0] played_reg, played_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic [SETTLE_W-1:0] settle_cfg_reg, settle_cfg_next;
    logic                s1_valid_reg, s1_valid_next;
    pss_entry_t          s1_reg, s1_next;

    logic             accept;
    logic             mem_we;
    logic             mem_re;
    logic             push_ok;
    logic             ring_empty;
    logic [IDX_W-1:0] fill_cur;
    logic [IDX_W-1:0] fill_after;
    logic [IDX_W-1:0] wr_inc;
    logic [IDX_W-1:0] need;
    logic [HOLD_W-1:0] phase_inc;

    assign accept     = in_valid && in_ready;
    assign in_ready   = !s1_valid_reg || entry_ready;
    assign entry_valid = s1_valid_reg;
    assign gain       = gain_reg;
    assign fill_cur   = wr_idx_reg - rd_idx_reg;
    assign ring_empty = (wr_idx_reg == rd_idx_reg);
    assign wr_inc     = wr_idx_reg + IDX_W'(1);
    assign push_ok    = running_reg && (wr_inc != rd_idx_reg);
    assign need       = drain_reg ? DRAIN_NEED : PRIME_NEED;
    assign phase_inc  = phase_reg + HOLD_W'(1);
    assign fill_after = wr_idx_next - rd_idx_next;

    always_comb
    begin
        entry        = s1_reg;
        entry.sample = rdata_reg;
    end

    always_comb
    begin
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        primed_next     = primed_reg;
        drain_next      = drain_reg;
        running_next    = running_reg;
        settle_next     = settle_reg;
        phase_next      = phase_reg;
        slot_next       = slot_reg;
        played_next     = played_reg;
        gain_next       = gain_reg;
        hold_next       = hold_reg;
        settle_cfg_next = settle_cfg_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        s1_next         = '0;
        s1_next.sel     = SEL_KEEP;

        if (accept)
        begin
            case (pss_action_t'(in_item.action))
                ACT_PUSH:
                begin
                    if (push_ok)
                    begin
                        mem_we           = 1'b1;
                        wr_idx_next      = wr_inc;
                        s1_next.accepted = 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    if (running_reg)
                    begin
                        s1_next.accepted = 1'b1;
                        s1_next.made_bit = 1'b1;
                        if (settle_reg != '0)
                        begin
                            settle_next = settle_reg - SETTLE_W'(1);
                            s1_next.sel = SEL_ZERO;
                        end
                        else if (phase_reg == '0)
                        begin
                            if (drain_reg && ring_empty)
                            begin
                                s1_next.finished = 1'b1;
                                s1_next.made_bit = 1'b0;
                            end
                            else
                            begin
                                s1_next.sel = SEL_ZERO;
                                if (primed_reg || (fill_cur >= need))
                                begin
                                    if (ring_empty)
                                    begin
                                        primed_next = 1'b0;
                                    end
                                    else
                                    begin
                                        primed_next = 1'b1;
                                        s1_next.sel = SEL_NEW;
                                        mem_re      = 1'b1;
                                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                                        if (played_reg != '1)
                                        begin
                                            played_next = played_reg + PLAYED_W'(1);
                                        end
                                    end
                                end
                            end
                        end
                        if (s1_next.made_bit)
                        begin
                            phase_next = (phase_inc == hold_reg) ? '0 : phase_inc;
                            if (slot_reg == SLOT_W'(SLOTS_PER_CYCLE - 1))
                            begin
                                slot_next   = '0;
                                s1_next.dur = DUR_W'(SHORT_US);
                            end
                            else
                            begin
                                slot_next   = slot_reg + SLOT_W'(1);
                                s1_next.dur = DUR_W'(LONG_US);
                            end
                        end
                    end
                end
                ACT_START:
                begin
                    if (!running_reg)
                    begin
                        drain_next   = 1'b0;
                        settle_next  = settle_cfg_reg;
                        running_next = 1'b1;
                    end
                    s1_next.accepted = 1'b1;
                end
                ACT_RESUME:
                begin
                    s1_next.accepted = running_reg;
                end
                ACT_STOP:
                begin
                    running_next     = 1'b0;
                    s1_next.accepted = 1'b1;
                end
                ACT_END:
                begin
                    drain_next       = 1'b1;
                    s1_next.accepted = 1'b1;
                end
                ACT_DRAIN:
                begin
                    if (running_reg)
                    begin
                        if (!ring_empty)
                        begin
                            primed_next = 1'b1;
                        end
                        drain_next       = 1'b1;
                        s1_next.accepted = 1'b1;
                    end
                end
                ACT_CLEAR:
                begin
                    if (!running_reg)
                    begin
                        wr_idx_next      = '0;
                        rd_idx_next      = '0;
                        primed_next      = 1'b0;
                        drain_next       = 1'b0;
                        settle_next      = '0;
                        played_next      = '0;
                        phase_next       = '0;
                        slot_next        = '0;
                        s1_next.sel      = SEL_CLEAR;
                        s1_next.accepted = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_en)
        begin
            case (cfg_index)
                CFG_GAIN:
                begin
                    gain_next = cfg_data[GAIN_W-1:0];
                end
                CFG_HOLD:
                begin
                    if (!running_reg && (cfg_data[HOLD_W-1:0] != '0))
                    begin
                        hold_next  = cfg_data[HOLD_W-1:0];
                        phase_next = '0;
                    end
                end
                CFG_SETTLE:
                begin
                    settle_cfg_next = cfg_data[SETTLE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        s1_next.fill   = fill_after[FILL_W-1:0];
        s1_next.played = played_next;

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (entry_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            primed_reg     <= 1'b0;
            drain_reg      <= 1'b0;
            running_reg    <= 1'b0;
            settle_reg     <= '0;
            phase_reg      <= '0;
            slot_reg       <= '0;
            played_reg     <= '0;
            gain_reg       <= GAIN_W'(2);
            hold_reg       <= HOLD_W'(3);
            settle_cfg_reg <= SETTLE_W'(4800);
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            primed_reg     <= primed_next;
            drain_reg      <= drain_next;
            running_reg    <= running_next;
            settle_reg     <= settle_next;
            phase_reg      <= phase_next;
            slot_reg       <= slot_next;
            played_reg     <= played_next;
            gain_reg       <= gain_next;
            hold_reg       <= hold_next;
            settle_cfg_reg <= settle_cfg_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring[wr_idx_reg] <= in_item.sample;
        end
        if (mem_re)
        begin
            rdata_reg <= ring[rd_idx_reg];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_item.action == ACT_PUSH) && push_ok) |=> (wr_idx_reg != rd_idx_reg))
        else $error("ring empty after a stored push");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> !ring_empty)
        else $error("ring read while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !entry_ready) |=> (s1_valid_reg && $stable(s1_reg) && $stable(rdata_reg)))
        else $error("stalled front entry changed");

endmodule

/* rtl/pss_queue.sv */
// Small register queue between front and back ends.
module pss_queue import pss_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  pss_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output pss_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    pss_entry_t slots [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/pss_back.sv */
// Back end: gain scaling, first-order sigma-delta accumulator and output register.
module pss_back import pss_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GAIN_W-1:0] gain,
    input  logic              entry_valid,
    output logic              entry_ready,
    input  pss_entry_t        entry,
    output logic              out_valid,
    input  logic              out_ready,
    output pss_out_t          out_item
);

    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(SAMPLE_MAX);
    localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(SAMPLE_MIN);
    localparam logic signed [ACC_W-1:0]  POS_STEP = ACC_W'(ACCUM_POS_STEP);
    localparam logic signed [ACC_W-1:0]  NEG_STEP = ACC_W'(ACCUM_NEG_STEP);
    localparam logic signed [ACC_W-1:0]  ACC_LO   = ACC_W'(SAMPLE_MIN);
    localparam logic signed [ACC_W-1:0]  ACC_HI   = ACC_W'(ACCUM_NEG_STEP);

    logic                       m_valid_reg, m_valid_next;
    pss_entry_t                 m_reg;
    logic signed [SAMPLE_W-1:0] m_scaled_reg;
    logic signed [SAMPLE_W-1:0] held_reg, held_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       out_valid_reg, out_valid_next;
    pss_out_t                   out_reg, out_next;

    logic                       adv;
    logic                       m_ready;
    logic                       m_load;
    logic                       a_load;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   half;
    logic signed [SAMPLE_W-1:0] scaled;
    logic signed [ACC_W-1:0]    sum;
    logic                       bit_val;

    assign adv         = !out_valid_reg || out_ready;
    assign m_ready     = !m_valid_reg || adv;
    assign entry_ready = m_ready;
    assign m_load      = entry_valid && m_ready;
    assign a_load      = m_valid_reg && adv;
    assign out_valid   = out_valid_reg;
    assign out_item    = out_reg;

    always_comb
    begin
        prod = PROD_W'($signed(entry.sample)) * PROD_W'($signed({1'b0, gain}));
        half = (prod + $signed({{(PROD_W-1){1'b0}}, prod[PROD_W-1]})) >>> 1;
        if (half > PROD_MAX)
        begin
            scaled = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (half < PROD_MIN)
        begin
            scaled = SAMPLE_W'(SAMPLE_MIN);
        end
        else
        begin
            scaled = half[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        held_next = held_reg;
        acc_next  = acc_reg;
        sum       = acc_reg;
        bit_val   = 1'b0;

        if (a_load)
        begin
            if (m_reg.sel == SEL_CLEAR)
            begin
                held_next = '0;
                acc_next  = '0;
            end
            if (m_reg.made_bit)
            begin
                case (m_reg.sel)
                    SEL_ZERO:
                    begin
                        held_next = '0;
                    end
                    SEL_NEW:
                    begin
                        held_next = m_scaled_reg;
                    end
                    default:
                    begin
                        held_next = held_reg;
                    end
                endcase
                sum      = acc_reg + ACC_W'(held_next);
                bit_val  = !sum[ACC_W-1];
                acc_next = bit_val ? sum - POS_STEP : sum + NEG_STEP;
            end
        end

        out_next.accepted    = m_reg.accepted;
        out_next.level       = bit_val;
        out_next.duration_us = m_reg.dur;
        out_next.finished    = m_reg.finished;
        out_next.fill        = m_reg.fill;
        out_next.played      = m_reg.played;

        m_valid_next   = m_load ? 1'b1 : (adv ? 1'b0 : m_valid_reg);
        out_valid_next = adv ? m_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            m_reg        <= entry;
            m_scaled_reg <= scaled;
        end
        if (a_load)
        begin
            out_reg <= out_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >= ACC_LO) && (acc_reg <= ACC_HI))
        else $error("sigma-delta accumulator out of range");

endmodule

/* rtl/pdm_sample_streamer.sv */
// Top level of the PDM sample streamer: front end, entry queue and modulator back end.
// Path: each item is registered in the front end, then in the entry queue, then in the back-end registers.
// Throughput: one item per cycle while out_ready holds; the ring is a single memory written on a push
// and read on a sample take, never both for the same item.
// Reset: rst_n clears all control state and restores gain 2, hold 3, settle 4800;
// ring contents are not cleared and there is no clearing pass.
module pdm_sample_streamer import pss_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pss_in_t               in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pss_out_t              out_item,
    input  logic                  cfg_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [GAIN_W-1:0] gain;
    logic              fq_valid;
    logic              fq_ready;
    pss_entry_t        fq_entry;
    logic              qb_valid;
    logic              qb_ready;
    pss_entry_t        qb_entry;

    pss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .cfg_en      (cfg_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .gain        (gain),
        .entry_valid (fq_valid),
        .entry_ready (fq_ready),
        .entry       (fq_entry)
    );

    pss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_entry (fq_entry),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_entry  (qb_entry)
    );

    pss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .gain        (gain),
        .entry_valid (qb_valid),
        .entry_ready (qb_ready),
        .entry       (qb_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule
